// ===== sv/isoa_pkg.sv =====
// Shared types and constants for the ISO 14443A anticollision reader.
package isoa_pkg;

  localparam int unsigned MAX_LEVELS = 3;
  localparam int unsigned UID_BYTES  = 10;
  localparam int unsigned FILL_W     = 4;
  localparam int unsigned UID_OUT    = 10;

  localparam logic [1:0] CMD_START     = 2'd0;
  localparam logic [1:0] CMD_FRAME     = 2'd1;
  localparam logic [1:0] CMD_COLLISION = 2'd2;
  localparam logic [1:0] CMD_TIMEOUT   = 2'd3;

  localparam logic [1:0] ACT_REQA = 2'd0;
  localparam logic [1:0] ACT_SEND = 2'd1;
  localparam logic [1:0] ACT_DONE = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NO_TAG    = 3'd1;
  localparam logic [2:0] ST_COLLISION = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_TIMEOUT   = 3'd4;

  localparam logic [7:0] CASCADE_TAG = 8'h88;
  localparam logic [7:0] SEL_BASE    = 8'h91;
  localparam logic [7:0] NVB_ANTI    = 8'h20;
  localparam logic [7:0] NVB_SELECT  = 8'h70;
  localparam int unsigned SAK_CASCADE_BIT = 2;

  localparam logic [2:0] ATQA_LEN    = 3'd2;
  localparam logic [2:0] ANTI_LEN    = 3'd5;
  localparam logic [2:0] SAK_MAX_LEN = 3'd3;
  localparam logic [2:0] TX_ANTI_LEN = 3'd2;
  localparam logic [2:0] TX_SEL_LEN  = 3'd7;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ATQA,
    PH_ANTI,
    PH_SAK
  } phase_t;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] rx_length;
    logic [7:0] rx_byte0;
    logic [7:0] rx_byte1;
    logic [7:0] rx_byte2;
    logic [7:0] rx_byte3;
    logic [7:0] rx_byte4;
  } req_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  tx_length;
    logic        tx_crc;
    logic [55:0] tx_frame;
    logic [2:0]  status;
    logic [15:0] atqa;
    logic [7:0]  sak;
    logic [63:0] uid_low;
    logic [15:0] uid_high;
    logic [3:0]  uid_count;
  } rsp_t;

endpackage

// ===== sv/isoa_seq.sv =====
// Card-detect sequencer: scan state and the result for the word being processed.
module isoa_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  isoa_pkg::req_t req,
  output isoa_pkg::rsp_t rsp
);
  import isoa_pkg::*;

  phase_t            phase, phase_next;
  logic [1:0]        level, level_next;
  logic [7:0]        uid_store [UID_BYTES];
  logic [7:0]        uid_store_next [UID_BYTES];
  logic [FILL_W-1:0] uid_fill, uid_fill_next;
  logic [15:0]       atqa_held, atqa_held_next;
  logic [7:0]        sak_held, sak_held_next;
  logic [2:0]        pend_len, pend_len_next;
  logic              pend_over, pend_over_next;

  logic [7:0]  part [4];
  logic [2:0]  part_cnt;
  logic [4:0]  wr_off;
  logic [7:0]  sel_code;
  logic [7:0]  uid_out [UID_OUT];
  logic        finish;
  logic        send_anti;
  logic [2:0]  fin_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      level     <= '0;
      uid_fill  <= '0;
      atqa_held <= '0;
      sak_held  <= '0;
      pend_len  <= '0;
      pend_over <= 1'b0;
    end else if (fire) begin
      phase     <= phase_next;
      level     <= level_next;
      uid_fill  <= uid_fill_next;
      atqa_held <= atqa_held_next;
      sak_held  <= sak_held_next;
      pend_len  <= pend_len_next;
      pend_over <= pend_over_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      uid_store <= uid_store_next;
    end
  end

  // The UID part skips the cascade tag when the reply opens with it.
  always_comb begin
    if (req.rx_byte0 == CASCADE_TAG) begin
      part[0]  = req.rx_byte1;
      part[1]  = req.rx_byte2;
      part[2]  = req.rx_byte3;
      part[3]  = req.rx_byte4;
      part_cnt = 3'd3;
    end else begin
      part[0]  = req.rx_byte0;
      part[1]  = req.rx_byte1;
      part[2]  = req.rx_byte2;
      part[3]  = req.rx_byte3;
      part_cnt = 3'd4;
    end
  end

  always_comb begin
    phase_next     = phase;
    level_next     = level;
    uid_store_next = uid_store;
    uid_fill_next  = uid_fill;
    atqa_held_next = atqa_held;
    sak_held_next  = sak_held;
    pend_len_next  = pend_len;
    pend_over_next = pend_over;
    finish         = 1'b0;
    send_anti      = 1'b0;
    fin_status     = ST_FOUND;
    wr_off         = '0;
    rsp            = '0;
    rsp.action     = ACT_NONE;

    if (req.command == CMD_START) begin
      phase_next     = PH_ATQA;
      level_next     = '0;
      uid_fill_next  = '0;
      atqa_held_next = '0;
      sak_held_next  = '0;
      pend_len_next  = '0;
      pend_over_next = 1'b0;
      rsp.action     = ACT_REQA;
    end else begin
      unique case (phase)
        PH_ATQA: begin
          if (req.command == CMD_TIMEOUT) begin
            finish = 1'b1; fin_status = ST_NO_TAG;
          end else if (req.command == CMD_COLLISION) begin
            finish = 1'b1; fin_status = ST_COLLISION;
          end else if (req.rx_length != ATQA_LEN) begin
            finish = 1'b1; fin_status = ST_INVALID;
          end else begin
            atqa_held_next = {req.rx_byte1, req.rx_byte0};
            if ({req.rx_byte1, req.rx_byte0} == 16'd0) begin
              finish = 1'b1; fin_status = ST_NO_TAG;
            end else begin
              level_next = 2'd1;
              send_anti  = 1'b1;
            end
          end
        end
        PH_ANTI: begin
          if (req.command == CMD_TIMEOUT) begin
            finish = 1'b1; fin_status = ST_TIMEOUT;
          end else if (req.command == CMD_COLLISION) begin
            finish = 1'b1; fin_status = ST_COLLISION;
          end else if (req.rx_length != ANTI_LEN ||
                       (req.rx_byte0 ^ req.rx_byte1 ^ req.rx_byte2 ^ req.rx_byte3)
                         != req.rx_byte4) begin
            finish = 1'b1; fin_status = ST_INVALID;
          end else begin
            pend_len_next  = part_cnt;
            pend_over_next = ({1'b0, uid_fill} + {2'b00, part_cnt}) > 5'(UID_BYTES);
            if (!pend_over_next) begin
              for (int j = 0; j < UID_BYTES; j++) begin
                wr_off = 5'(j) - {1'b0, uid_fill};
                if (wr_off < {2'b00, part_cnt}) begin
                  uid_store_next[j] = part[wr_off[1:0]];
                end
              end
            end
            phase_next    = PH_SAK;
            rsp.action    = ACT_SEND;
            rsp.tx_length = TX_SEL_LEN;
            rsp.tx_crc    = 1'b1;
            rsp.tx_frame  = {req.rx_byte4, req.rx_byte3, req.rx_byte2, req.rx_byte1,
                             req.rx_byte0, NVB_SELECT, SEL_BASE + {5'd0, level, 1'b0}};
          end
        end
        PH_SAK: begin
          if (req.command == CMD_COLLISION) begin
            rsp.action = ACT_NONE;
          end else if (req.command == CMD_TIMEOUT) begin
            finish = 1'b1; fin_status = ST_TIMEOUT;
          end else if (req.rx_length < 3'd1 || req.rx_length > SAK_MAX_LEN) begin
            finish = 1'b1; fin_status = ST_INVALID;
          end else begin
            sak_held_next = req.rx_byte0;
            if (pend_over) begin
              finish = 1'b1; fin_status = ST_INVALID;
            end else begin
              uid_fill_next = uid_fill + FILL_W'(pend_len);
              pend_len_next = '0;
              if (!req.rx_byte0[SAK_CASCADE_BIT]) begin
                finish = 1'b1; fin_status = ST_FOUND;
              end else if (32'(level) >= MAX_LEVELS) begin
                finish = 1'b1; fin_status = ST_INVALID;
              end else begin
                level_next = level + 2'd1;
                send_anti  = 1'b1;
              end
            end
          end
        end
        PH_IDLE: begin
          rsp.action = ACT_NONE;
        end
        default: begin
          rsp.action = ACT_NONE;
        end
      endcase
    end

    sel_code = SEL_BASE + {5'd0, level_next, 1'b0};
    if (send_anti) begin
      phase_next    = PH_ANTI;
      rsp.action    = ACT_SEND;
      rsp.tx_length = TX_ANTI_LEN;
      rsp.tx_crc    = 1'b0;
      rsp.tx_frame  = {40'd0, NVB_ANTI, sel_code};
    end
    if (finish) begin
      phase_next = PH_IDLE;
      rsp.action = ACT_DONE;
      rsp.status = fin_status;
    end

    for (int i = 0; i < UID_OUT; i++) begin
      uid_out[i] = '0;
      if (i < UID_BYTES && FILL_W'(i) < uid_fill_next) begin
        uid_out[i] = uid_store_next[i];
      end
    end
    for (int i = 0; i < 8; i++) begin
      rsp.uid_low[8*i +: 8] = uid_out[i];
    end
    rsp.uid_high  = {uid_out[9], uid_out[8]};
    rsp.atqa      = atqa_held_next;
    rsp.sak       = sak_held_next;
    rsp.uid_count = 4'(uid_fill_next);
  end

endmodule

// ===== sv/iso14443a_anticollision_reader_top.sv =====
// Top level of the ISO 14443A reader card-detect sequencer.
// The req channel carries one event word per transfer: a start, a received
// frame, a collision or a response timeout, with up to five received bytes.
// The rsp channel returns exactly one word per event: the action to take
// (send REQA, send a frame, scan finished or nothing), the frame to send,
// the final status, and the ATQA, SAK and UID gathered so far.
// An accepted event is held in an input register and evaluated by the
// sequencer into the result register, which takes the result once it is
// free; until then the event waits in the input register.
// One event per cycle is sustained while rsp_ready stays high, with the
// evaluation between the two registers purely combinational.
// When the receiver stalls, the result register holds its word and the
// input register still takes one more event; req_ready drops only while
// both are full and rsp_ready is low. A start event clears the scan state
// in any phase.
// Reset empties both registers and returns the sequencer to idle with
// the ATQA, SAK and UID count at zero.
module iso14443a_anticollision_reader_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  isoa_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output isoa_pkg::rsp_t rsp
);
  import isoa_pkg::*;

  req_t in_q;
  logic in_q_valid;
  rsp_t step_rsp;
  logic advance;

  assign advance   = in_q_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        in_q_valid <= 1'b1;
      end else if (advance) begin
        in_q_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      in_q <= req;
    end
    if (advance) begin
      rsp <= step_rsp;
    end
  end

  isoa_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .req  (in_q),
    .rsp  (step_rsp)
  );

`ifndef SYNTHESIS
  a_tx_only_on_send: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.action != ACT_SEND |-> rsp.tx_length == 3'd0 && rsp.tx_frame == '0)
    else $error("Frame data present on a word that sends nothing.");

  a_status_only_on_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.action != ACT_DONE |-> rsp.status == ST_FOUND)
    else $error("Status set on a word that does not finish the scan.");

  a_uid_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp.uid_count) <= UID_BYTES)
    else $error("UID count beyond the store size.");

  a_held_event_kept: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && rsp_valid && !rsp_ready |=> in_q_valid && $stable(in_q))
    else $error("Pending event word lost while the result was stalled.");
`endif

endmodule
